/* hw/rtl/bfa_pkg.sv */
// shared types, constants and helpers for the best-fit free-list allocator
package bfa_pkg;

   localparam int POOL_BYTES    = 262144;
   localparam int GRANULE_BYTES = 32;
   localparam int GRAN_LOG      = $clog2(GRANULE_BYTES);
   localparam int NGRAN         = POOL_BYTES / GRANULE_BYTES;
   localparam int GIW           = $clog2(NGRAN);      // granule index
   localparam int LENW          = GIW + 1;            // extent length in granules
   localparam int GW            = 15;                 // rounded request in granules
   localparam int CMDW          = 2;
   localparam int STATW         = 2;
   localparam int BYTEW         = 19;
   localparam int ADDRW         = 18;
   localparam int REQ_DATA_W    = 40;
   localparam int RSP_DATA_W    = 56;

   typedef enum logic [CMDW-1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_DEFRAG = 2'd2,
      CMD_INIT   = 2'd3
   } cmd_type;

   typedef enum logic [STATW-1:0] {
      STAT_OK    = 2'd0,
      STAT_NOFIT = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_ALLOC_SCAN,
      S_ALLOC_FIT,
      S_SIZE_WR,
      S_RM_START,
      S_SHIFT_DOWN,
      S_FREE_RD,
      S_FREE_SCAN,
      S_SHIFT_UP,
      S_HEAD_WR,
      S_DF_START,
      S_DF_RDI,
      S_DF_SCANJ,
      S_DF_GROW,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [GIW-1:0]  start;
      logic [LENW-1:0] len;
   } ext_type;

   typedef struct packed {
      status_type       status;
      logic [ADDRW-1:0] data_address;
      logic [BYTEW-1:0] granted_bytes;
      logic [BYTEW-1:0] bytes_left;
   } rsp_type;

   // merged length, capped at the pool size
   function automatic logic [LENW-1:0] sat_len(input logic [LENW-1:0] a,
                                               input logic [LENW-1:0] b);
      logic [LENW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s > (LENW+1)'(NGRAN))
         return LENW'(NGRAN);
      return s[LENW-1:0];
   endfunction

   // free total after a block is returned, capped at the pool size
   function automatic logic [BYTEW-1:0] add_total(input logic [BYTEW-1:0] t,
                                                  input logic [BYTEW-1:0] b);
      logic [BYTEW:0] s;
      s = {1'b0, t} + {1'b0, b};
      if (s > (BYTEW+1)'(POOL_BYTES))
         return BYTEW'(POOL_BYTES);
      return s[BYTEW-1:0];
   endfunction

endpackage

/* hw/rtl/bfa_ext_mem.sv */
// free extent table memory, one read and one write port, registered read
module bfa_ext_mem #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output bfa_pkg::ext_type         rdata,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  bfa_pkg::ext_type         wdata
);
   import bfa_pkg::*;

   ext_type mem [DEPTH];
   ext_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/bfa_size_mem.sv */
// per-granule block size memory, one read and one write port, registered read
module bfa_size_mem (
   input  logic                        clock,
   input  logic [bfa_pkg::GIW-1:0]     raddr,
   output logic [bfa_pkg::LENW-1:0]    rdata,
   input  logic                        we,
   input  logic [bfa_pkg::GIW-1:0]     waddr,
   input  logic [bfa_pkg::LENW-1:0]    wdata
);
   import bfa_pkg::*;

   logic [LENW-1:0] mem [NGRAN];
   logic [LENW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/bfa_ctrl.sv */
// command sequencer: scans, shifts and updates the extent table
module bfa_ctrl #(
   parameter int MAX_EXTENTS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bfa_pkg::cmd_type                 req_cmd,
   input  logic [bfa_pkg::BYTEW-1:0]        req_bytes,
   input  logic [bfa_pkg::ADDRW-1:0]        req_addr,
   input  logic                             can_load,
   output logic                             rsp_load,
   output bfa_pkg::rsp_type                 rsp,
   output logic [$clog2(MAX_EXTENTS)-1:0]   ext_raddr,
   input  bfa_pkg::ext_type                 ext_rdata,
   output logic                             ext_we,
   output logic [$clog2(MAX_EXTENTS)-1:0]   ext_waddr,
   output bfa_pkg::ext_type                 ext_wdata,
   output logic [bfa_pkg::GIW-1:0]          sz_raddr,
   input  logic [bfa_pkg::LENW-1:0]         sz_rdata,
   output logic                             sz_we,
   output logic [bfa_pkg::GIW-1:0]          sz_waddr,
   output logic [bfa_pkg::LENW-1:0]         sz_wdata
);
   import bfa_pkg::*;

   localparam int AW = $clog2(MAX_EXTENTS);
   localparam int CW = $clog2(MAX_EXTENTS + 1);

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [BYTEW-1:0] total_ff, total_in;
   logic [GW-1:0]    g_ff, g_in;
   logic [GIW-1:0]   gi_ff, gi_in;
   logic [LENW-1:0]  sz_ff, sz_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    j_ff, j_in;
   logic [CW-1:0]    sh_ff, sh_in;
   logic             found_ff, found_in;
   logic [CW-1:0]    best_ff, best_in;
   logic [GIW-1:0]   bst_ff, bst_in;
   logic [LENW-1:0]  blen_ff, blen_in;
   logic [LENW-1:0]  blk_ff, blk_in;
   logic [LENW-1:0]  lenj_ff, lenj_in;
   logic [GIW-1:0]   ist_ff, ist_in;
   logic [LENW-1:0]  ilen_ff, ilen_in;
   status_type       stat_ff, stat_in;
   logic [ADDRW-1:0] data_ff, data_in;
   logic [BYTEW-1:0] gr_ff, gr_in;

   logic             accept;
   logic [CW-1:0]    idx_nx, j_nx, sh_nx;
   logic             idx_last, j_last, sh_last, tbl_full;
   logic [LENW-1:0]  cur_end, i_end;
   logic             a_exact, a_better, f_match, d_match;
   logic [ADDRW-1:0] addr_off;
   logic [BYTEW+1:0] g_sum;
   logic [BYTEW-1:0] g_bytes, sz_bytes;
   state_type        after_rm;

   assign accept   = req_valid && (state_ff == S_IDLE);
   assign idx_nx   = idx_ff + CW'(1);
   assign j_nx     = j_ff + CW'(1);
   assign sh_nx    = sh_ff + CW'(1);
   assign idx_last = (idx_nx == cnt_ff);
   assign j_last   = (j_nx == cnt_ff);
   assign sh_last  = (sh_nx >= cnt_ff);
   assign tbl_full = (cnt_ff >= CW'(MAX_EXTENTS));
   assign cur_end  = {1'b0, ext_rdata.start} + ext_rdata.len;
   assign i_end    = {1'b0, ist_ff} + ilen_ff;
   assign a_exact  = ({1'b0, ext_rdata.len} == g_ff);
   assign a_better = ({1'b0, ext_rdata.len} > g_ff) && (!found_ff || ext_rdata.len < blen_ff);
   assign f_match  = (cur_end == {1'b0, gi_ff});
   assign d_match  = ({1'b0, ext_rdata.start} == i_end);
   assign addr_off = req_addr - ADDRW'(4);
   assign g_sum    = {2'b00, req_bytes} + (BYTEW+2)'(4 + GRANULE_BYTES - 1);
   assign g_bytes  = BYTEW'({g_ff, {GRAN_LOG{1'b0}}});
   assign sz_bytes = BYTEW'({sz_rdata, {GRAN_LOG{1'b0}}});
   assign after_rm = (cmd_ff == CMD_ALLOC) ? S_SIZE_WR : S_DF_START;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: state_in = S_IDLE;
         S_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_ALLOC:  state_in = (cnt_ff == '0) ? S_RESP : S_ALLOC_SCAN;
                  CMD_FREE:   state_in = S_FREE_RD;
                  CMD_DEFRAG: state_in = (cnt_ff == '0) ? S_RESP : S_DF_START;
                  default:    state_in = S_RESP;
               endcase
            end
         end
         S_ALLOC_SCAN: begin
            if (a_exact)
               state_in = S_RM_START;
            else if (idx_last)
               state_in = (found_ff || a_better) ? S_ALLOC_FIT : S_RESP;
         end
         S_ALLOC_FIT: state_in = S_SIZE_WR;
         S_SIZE_WR:   state_in = S_RESP;
         S_RM_START:  state_in = sh_last ? after_rm : S_SHIFT_DOWN;
         S_SHIFT_DOWN: begin
            if (sh_last)
               state_in = after_rm;
         end
         S_FREE_RD: state_in = (cnt_ff == '0) ? S_HEAD_WR : S_FREE_SCAN;
         S_FREE_SCAN: begin
            if (f_match)
               state_in = S_RESP;
            else if (idx_last)
               state_in = tbl_full ? S_RESP : S_SHIFT_UP;
         end
         S_SHIFT_UP: begin
            if (sh_ff == '0)
               state_in = S_HEAD_WR;
         end
         S_HEAD_WR:  state_in = S_RESP;
         S_DF_START: state_in = S_DF_RDI;
         S_DF_RDI:   state_in = S_DF_SCANJ;
         S_DF_SCANJ: begin
            if (d_match)
               state_in = (j_ff == idx_ff) ? S_RM_START : S_DF_GROW;
            else if (j_last)
               state_in = idx_last ? S_RESP : S_DF_RDI;
         end
         S_DF_GROW: state_in = S_RM_START;
         S_RESP: begin
            if (can_load)
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // memory ports and handshake
   always_comb begin
      req_ready = (state_ff == S_IDLE);
      rsp_load  = (state_ff == S_RESP) && can_load;
      ext_raddr = '0;
      ext_we    = 1'b0;
      ext_waddr = '0;
      ext_wdata = ext_rdata;
      sz_raddr  = addr_off[GRAN_LOG +: GIW];
      sz_we     = 1'b0;
      sz_waddr  = blk_ff[GIW-1:0];
      sz_wdata  = g_ff[LENW-1:0];
      case (state_ff)
         S_INIT: begin
            ext_we    = 1'b1;
            ext_wdata = '{start: '0, len: LENW'(NGRAN)};
         end
         S_IDLE: begin
            if (accept && req_cmd == CMD_INIT) begin
               ext_we    = 1'b1;
               ext_wdata = '{start: '0, len: LENW'(NGRAN)};
            end
         end
         S_ALLOC_SCAN: ext_raddr = idx_nx[AW-1:0];
         S_ALLOC_FIT: begin
            ext_we    = 1'b1;
            ext_waddr = best_ff[AW-1:0];
            ext_wdata = '{start: bst_ff, len: blen_ff - g_ff[LENW-1:0]};
         end
         S_SIZE_WR: sz_we = 1'b1;
         S_RM_START: ext_raddr = sh_nx[AW-1:0];
         S_SHIFT_DOWN: begin
            ext_raddr = sh_nx[AW-1:0];
            ext_we    = 1'b1;
            ext_waddr = AW'(sh_ff - CW'(1));
         end
         S_FREE_SCAN: begin
            ext_raddr = idx_last ? AW'(cnt_ff - CW'(1)) : idx_nx[AW-1:0];
            if (f_match) begin
               ext_we    = 1'b1;
               ext_waddr = idx_ff[AW-1:0];
               ext_wdata = '{start: ext_rdata.start, len: sat_len(ext_rdata.len, sz_ff)};
            end
         end
         S_SHIFT_UP: begin
            ext_raddr = AW'(sh_ff - CW'(1));
            ext_we    = 1'b1;
            ext_waddr = AW'(sh_nx);
         end
         S_HEAD_WR: begin
            ext_we    = 1'b1;
            ext_wdata = '{start: gi_ff, len: sz_ff};
         end
         S_DF_SCANJ: begin
            ext_raddr = j_last ? idx_nx[AW-1:0] : j_nx[AW-1:0];
         end
         S_DF_GROW: begin
            ext_we    = 1'b1;
            ext_waddr = idx_ff[AW-1:0];
            ext_wdata = '{start: ist_ff, len: sat_len(ilen_ff, lenj_ff)};
         end
         default: ;
      endcase
   end

   // datapath registers
   always_comb begin
      cmd_in   = cmd_ff;
      cnt_in   = cnt_ff;
      total_in = total_ff;
      g_in     = g_ff;
      gi_in    = gi_ff;
      sz_in    = sz_ff;
      idx_in   = idx_ff;
      j_in     = j_ff;
      sh_in    = sh_ff;
      found_in = found_ff;
      best_in  = best_ff;
      bst_in   = bst_ff;
      blen_in  = blen_ff;
      blk_in   = blk_ff;
      lenj_in  = lenj_ff;
      ist_in   = ist_ff;
      ilen_in  = ilen_ff;
      stat_in  = stat_ff;
      data_in  = data_ff;
      gr_in    = gr_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_cmd;
               g_in     = g_sum[GRAN_LOG +: GW];
               gi_in    = addr_off[GRAN_LOG +: GIW];
               idx_in   = '0;
               found_in = 1'b0;
               stat_in  = STAT_OK;
               data_in  = '0;
               gr_in    = '0;
               if (req_cmd == CMD_ALLOC && cnt_ff == '0)
                  stat_in = STAT_NOFIT;
               if (req_cmd == CMD_INIT) begin
                  cnt_in   = CW'(1);
                  total_in = BYTEW'(POOL_BYTES);
               end
            end
         end
         S_ALLOC_SCAN: begin
            idx_in = idx_nx;
            if (a_exact) begin
               blk_in = {1'b0, ext_rdata.start};
               sh_in  = idx_ff;
            end else begin
               if (a_better) begin
                  found_in = 1'b1;
                  best_in  = idx_ff;
                  bst_in   = ext_rdata.start;
                  blen_in  = ext_rdata.len;
               end
               if (idx_last && !(found_ff || a_better))
                  stat_in = STAT_NOFIT;
            end
         end
         S_ALLOC_FIT: blk_in = {1'b0, bst_ff} + (blen_ff - g_ff[LENW-1:0]);
         S_SIZE_WR: begin
            data_in  = ADDRW'({blk_ff, {GRAN_LOG{1'b0}}}) + ADDRW'(4);
            gr_in    = g_bytes;
            total_in = (total_ff > g_bytes) ? total_ff - g_bytes : '0;
         end
         S_RM_START: begin
            if (sh_last)
               cnt_in = cnt_ff - CW'(1);
            else
               sh_in = sh_nx;
         end
         S_SHIFT_DOWN: begin
            if (sh_last)
               cnt_in = cnt_ff - CW'(1);
            else
               sh_in = sh_nx;
         end
         S_FREE_RD: begin
            sz_in  = sz_rdata;
            gr_in  = sz_bytes;
            idx_in = '0;
         end
         S_FREE_SCAN: begin
            idx_in = idx_nx;
            if (f_match)
               total_in = add_total(total_ff, gr_ff);
            else if (idx_last) begin
               if (tbl_full)
                  stat_in = STAT_FULL;
               else
                  sh_in = cnt_ff - CW'(1);
            end
         end
         S_SHIFT_UP: sh_in = sh_ff - CW'(1);
         S_HEAD_WR: begin
            cnt_in   = cnt_ff + CW'(1);
            total_in = add_total(total_ff, gr_ff);
         end
         S_DF_START: idx_in = '0;
         S_DF_RDI: begin
            ist_in  = ext_rdata.start;
            ilen_in = ext_rdata.len;
            j_in    = '0;
         end
         S_DF_SCANJ: begin
            j_in = j_nx;
            if (d_match) begin
               sh_in   = j_ff;
               lenj_in = ext_rdata.len;
            end else if (j_last) begin
               idx_in = idx_nx;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cnt_ff   <= CW'(1);
         total_ff <= BYTEW'(POOL_BYTES);
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         total_ff <= total_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      g_ff    <= g_in;
      gi_ff   <= gi_in;
      sz_ff   <= sz_in;
      idx_ff  <= idx_in;
      j_ff    <= j_in;
      sh_ff   <= sh_in;
      best_ff <= best_in;
      bst_ff  <= bst_in;
      blen_ff <= blen_in;
      blk_ff  <= blk_in;
      lenj_ff <= lenj_in;
      ist_ff  <= ist_in;
      ilen_ff <= ilen_in;
      stat_ff <= stat_in;
      data_ff <= data_in;
      gr_ff   <= gr_in;
   end

   assign rsp = '{status: stat_ff, data_address: data_ff, granted_bytes: gr_ff,
                  bytes_left: total_ff};

endmodule

/* hw/rtl/best_fit_free_list_allocator.sv */
// top level of the best-fit free-list allocator
// allocate scans the n extents and may shift the table down, free scans them and merges,
//   or shifts the table up for a head insert; the extent memory port reads one entry per cycle
// defragment: scans pairs of extents, merges abutting ones with a removal shift, repeated
//   until nothing abuts; reinitialize rewrites the table; one item in flight at a time
// reset: synchronous; an init state writes the whole-pool extent before the first item
// a result waits in the output register while the next item is taken
module best_fit_free_list_allocator #(
   parameter int MAX_EXTENTS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // request_bytes [18:0], block_address [36:19], zero fill [39:37]
   input  logic [bfa_pkg::REQ_DATA_W-1:0]    req_tdata,
   // command [1:0]
   input  logic [bfa_pkg::CMDW-1:0]          req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // data_address [17:0], granted_bytes [36:18], bytes_left [55:37]
   output logic [bfa_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status [1:0]
   output logic [bfa_pkg::STATW-1:0]         rsp_tuser
);
   import bfa_pkg::*;

   localparam int AW = $clog2(MAX_EXTENTS);

   // extent table port
   logic [AW-1:0]   ext_raddr, ext_waddr;
   ext_type         ext_rdata, ext_wdata;
   logic            ext_we;
   // block size port
   logic [GIW-1:0]  sz_raddr, sz_waddr;
   logic [LENW-1:0] sz_rdata, sz_wdata;
   logic            sz_we;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;
   rsp_type         rsp_new;
   logic            can_load, rsp_load;

   assign can_load = !rsp_valid_ff || rsp_tready;

   bfa_ctrl #(
      .MAX_EXTENTS (MAX_EXTENTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (cmd_type'(req_tuser)),
      .req_bytes (req_tdata[BYTEW-1:0]),
      .req_addr  (req_tdata[BYTEW +: ADDRW]),
      .can_load  (can_load),
      .rsp_load  (rsp_load),
      .rsp       (rsp_new),
      .ext_raddr (ext_raddr),
      .ext_rdata (ext_rdata),
      .ext_we    (ext_we),
      .ext_waddr (ext_waddr),
      .ext_wdata (ext_wdata),
      .sz_raddr  (sz_raddr),
      .sz_rdata  (sz_rdata),
      .sz_we     (sz_we),
      .sz_waddr  (sz_waddr),
      .sz_wdata  (sz_wdata)
   );

   bfa_ext_mem #(
      .DEPTH (MAX_EXTENTS)
   ) u_ext_mem (
      .clock (clock),
      .raddr (ext_raddr),
      .rdata (ext_rdata),
      .we    (ext_we),
      .waddr (ext_waddr),
      .wdata (ext_wdata)
   );

   bfa_size_mem u_size_mem (
      .clock (clock),
      .raddr (sz_raddr),
      .rdata (sz_rdata),
      .we    (sz_we),
      .waddr (sz_waddr),
      .wdata (sz_wdata)
   );

   // output stage: load a finished item, hold it until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready)
         rsp_valid_in = 1'b0;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rsp_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.bytes_left, rsp_ff.granted_bytes, rsp_ff.data_address};
   assign rsp_tuser  = rsp_ff.status;

endmodule
